// ===== rtl/sce_pkg.sv =====
`timescale 1ns / 1ps

package sce_pkg;

    localparam int CFG_W    = 11;
    localparam int ENERGY_W = 10;
    localparam int CUM_W    = 21;

    localparam logic [CUM_W-1:0] SAT_MAX = {CUM_W{1'b1}};

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_WIDTH      = 4;
    localparam int MIN_HEIGHT     = 3;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(1024);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

// ===== rtl/seam_cumulative_energy_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------------
// pixel    | in        | i_in_valid / o_in_ready   | i_pixel_energy
// result   | out       | o_out_valid / i_out_ready | o_cumulative_energy, o_value_defined,
//          |           |                           | o_row_end, o_frame_end
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel per clock is sustained unless the output stalls; a taken beat is held in the compute
// stage, then in the output register. The line store is read once per pixel (at acceptance)
// and written once per defined pixel (in the compute stage). Reset clears the position counters
// and pipeline valids and sets the frame size registers to 1024; the line store is not cleared
// and only entries written in the previous row are used. A stalled output holds its beat, the
// compute stage keeps filling, and input stalls only when both are full.

module seam_cumulative_energy_unit #(
    parameter int MAX_WIDTH  = sce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sce_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sce_pkg::ENERGY_W-1:0]  i_pixel_energy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sce_pkg::CUM_W-1:0]     o_cumulative_energy,
    output logic                          o_value_defined,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  sce_pkg::t_cfg_idx             i_cfg_index,
    input  logic [sce_pkg::CFG_W-1:0]     i_cfg_data
);
    import sce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped frame size.
    logic [WW-1:0] w_raw;
    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_raw;
    logic [HW-1:0] h_clamp;

    always_comb begin
        w_raw = WW'(r_frame_width);
        h_raw = HW'(r_frame_height);
        if (w_raw < WW'(MIN_WIDTH)) begin
            w_clamp = WW'(MIN_WIDTH);
        end else if (w_raw > WW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (h_raw < HW'(MIN_HEIGHT)) begin
            h_clamp = HW'(MIN_HEIGHT);
        end else if (h_raw > HW'(MAX_HEIGHT)) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = h_raw;
        end
    end

    // Pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Position counters and acceptance-stage decode.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          last_col;
    logic          last_row;
    logic          cell_defined;

    assign last_col     = WW'(r_col) >= (w_clamp - WW'(1));
    assign last_row     = HW'(r_row) >= (h_clamp - HW'(1));
    assign cell_defined = !last_col && (r_col != '0) && !last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Line store holding the previous row's cumulative values.
    logic [CUM_W-1:0] mem [MAX_WIDTH];
    logic [CUM_W-1:0] r_rd_data;
    logic [CW-1:0]    rd_addr;
    logic             wr_en;
    logic [CUM_W-1:0] wr_data;
    logic [CW-1:0]    r_s1_col;

    // The upper-right neighbour is fetched as the pixel is taken.
    assign rd_addr = r_col + CW'(1);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_s1_col] <= wr_data;
        end
    end

    // Compute stage.
    logic [ENERGY_W-1:0] r_s1_energy;
    logic                r_s1_defined;
    logic                r_s1_top;
    logic                r_s1_first;
    logic                r_s1_near_right;
    logic                r_s1_row_end;
    logic                r_s1_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_energy     <= i_pixel_energy;
            r_s1_col        <= r_col;
            r_s1_defined    <= cell_defined;
            r_s1_top        <= (r_row == '0);
            r_s1_first      <= (r_col == CW'(1));
            r_s1_near_right <= (WW'(r_col) == (w_clamp - WW'(2)));
            r_s1_row_end    <= last_col;
            r_s1_frame_end  <= last_col && last_row;
        end
    end

    // Sliding window over the previous row: r_up is the entry above the pixel in the
    // compute stage, r_ul the entry above the last defined pixel, both read before this
    // row overwrote them.
    logic [CUM_W-1:0] r_up;
    logic [CUM_W-1:0] r_ul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
            r_ul <= '0;
        end else if (s1_adv) begin
            if (r_s1_defined) begin
                r_ul <= r_up;
            end
            r_up <= r_rd_data;
        end
    end

    logic [CUM_W-1:0] best;
    logic [CUM_W:0]   sum;
    logic [CUM_W-1:0] value;

    always_comb begin
        best = r_up;
        if (!r_s1_first && (r_ul < best)) begin
            best = r_ul;
        end
        if (!r_s1_near_right && (r_rd_data < best)) begin
            best = r_rd_data;
        end
        sum = (CUM_W + 1)'(r_s1_energy) + (CUM_W + 1)'(best);
        if (!r_s1_defined || r_s1_top) begin
            value = '0;
        end else if (sum > (CUM_W + 1)'(SAT_MAX)) begin
            value = SAT_MAX;
        end else begin
            value = sum[CUM_W-1:0];
        end
    end

    assign wr_en   = s1_adv && r_s1_defined;
    assign wr_data = value;

    // Output register.
    logic [CUM_W-1:0] r_out_cum;
    logic             r_out_defined;
    logic             r_out_row_end;
    logic             r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cum       <= value;
            r_out_defined   <= r_s1_defined;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_cumulative_energy = r_out_cum;
    assign o_value_defined     = r_out_defined;
    assign o_row_end           = r_out_row_end;
    assign o_frame_end         = r_out_frame_end;

    // The fetch of the next pixel's neighbour never hits the entry being written back.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && in_acc) |-> (rd_addr != r_s1_col))
        else $error("line store read and write collide");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_value_defined) |-> (o_cumulative_energy == '0))
        else $error("border pixel carries a nonzero value");

    a_row_end_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_end) |-> !o_value_defined)
        else $error("last column flagged as defined");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col)))
        else $error("stalled compute stage lost its pixel");

endmodule
